>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> hw/rtl/tbeq_pkg.sv
// Package for the touch button event qualifier: widths, codes, reset values.
`timescale 1ns / 1ps

package tbeq_pkg;

    localparam int SampleW = 16;
    localparam int TimeW   = 32;
    localparam int CfgW    = 16;
    localparam int CfgIdxW = 2;
    localparam int EvW     = 2;
    localparam int InW     = SampleW + TimeW;   // 48, already whole bytes
    localparam int OutW    = 8;                 // 3 bits of payload, padded

    // event codes
    localparam logic [EvW-1:0] EV_NONE    = 2'd0;
    localparam logic [EvW-1:0] EV_PRESS   = 2'd1;
    localparam logic [EvW-1:0] EV_RELEASE = 2'd2;
    localparam logic [EvW-1:0] EV_HOLD    = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_HOLD      = 2'd2;

    // configuration reset values
    localparam logic [CfgW-1:0] THRESHOLD_RST = 16'd0;
    localparam logic [CfgW-1:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [CfgW-1:0] HOLD_RST      = 16'd500;

endpackage

>>> hw/rtl/touch_button_event_qualifier_unit.sv
// Top level of the touch button event qualifier.
`timescale 1ns / 1ps

// Debounced capacitive touch button with press, release and long-press
// (hold) events. Every input transfer carries one raw sample and a ms
// timestamp and yields exactly one output transfer with an event code and
// the debounced touched state. A sample strictly below touch_threshold is
// touched. The raw level must stay unchanged for strictly more than
// debounce_ms before the debounced state follows it (press or release); a
// hold event fires once per press when the touch lasts strictly more than
// hold_ms, and yields to press/release in the same item. Time differences
// wrap modulo 2^32. Throughput is one item per clock unless stalled. Items
// pass input register, then result register. The per-item state update
// (one 16-bit compare and two 32-bit subtract-and-compare paths) sits
// between those two registers, so each item sees the state left by the
// previous one. Configuration registers: index 0 touch_threshold (reset 0),
// 1 debounce_ms (reset 50), 2 hold_ms (reset 500); index 3 is ignored.
// Write them only while no transfer is in flight.
module touch_button_event_qualifier_unit
    import tbeq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [InW-1:0]     s_tdata,   // [15:0] raw_sample, [47:16] now_ms
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OutW-1:0]    m_tdata,   // [1:0] event_code, [2] stable_touched, [7:3] zero
    // configuration write port
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data
);

    // configuration
    logic [CfgW-1:0]    threshold_reg;
    logic [CfgW-1:0]    debounce_reg;
    logic [CfgW-1:0]    hold_reg;

    // input register
    logic               in_valid_reg;
    logic [SampleW-1:0] in_sample_reg;
    logic [TimeW-1:0]   in_now_reg;

    // button state
    logic               prev_raw_reg;
    logic [TimeW-1:0]   change_time_reg;
    logic               deb_level_reg;
    logic [TimeW-1:0]   press_time_reg;
    logic               hold_fired_reg;

    // result register
    logic               out_valid_reg;
    logic [EvW-1:0]     out_ev_reg;
    logic               out_stable_reg;

    // step logic
    logic               advance;
    logic               raw;
    logic               raw_changed;
    logic [TimeW-1:0]   since_change;
    logic [TimeW-1:0]   since_press;
    logic               deb_flip;
    logic               hold_hit;
    logic [EvW-1:0]     ev_next;
    logic               deb_level_next;

    // The result register takes a new item when empty or being drained;
    // the input register refills in the same cycle it hands off.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutW - EvW - 1){1'b0}}, out_stable_reg, out_ev_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            debounce_reg  <= DEBOUNCE_RST;
            hold_reg      <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_DEBOUNCE:  debounce_reg  <= cfg_data;
                REG_HOLD:      hold_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Input register payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg <= s_tdata[SampleW-1:0];
            in_now_reg    <= s_tdata[InW-1:SampleW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // A raw change restarts the timer, so the elapsed time is then zero and
    // never exceeds debounce_ms. Likewise a fresh press has zero hold time,
    // so hold can only fire when the debounced level did not move.
    always_comb
    begin
        raw          = in_sample_reg < threshold_reg;
        raw_changed  = raw != prev_raw_reg;
        since_change = in_now_reg - change_time_reg;
        since_press  = in_now_reg - press_time_reg;
        deb_flip     = !raw_changed && (raw != deb_level_reg)
                       && (since_change > {{(TimeW - CfgW){1'b0}}, debounce_reg});
        hold_hit     = !deb_flip && deb_level_reg && !hold_fired_reg
                       && (since_press > {{(TimeW - CfgW){1'b0}}, hold_reg});
        deb_level_next = deb_flip ? raw : deb_level_reg;

        if (hold_hit)
            ev_next = EV_HOLD;
        else if (deb_flip && raw)
            ev_next = EV_PRESS;
        else if (deb_flip)
            ev_next = EV_RELEASE;
        else
            ev_next = EV_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= 1'b0;
            change_time_reg <= '0;
            deb_level_reg   <= 1'b0;
            press_time_reg  <= '0;
            hold_fired_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prev_raw_reg  <= raw;
            deb_level_reg <= deb_level_next;
            if (raw_changed)
                change_time_reg <= in_now_reg;
            if (deb_flip && raw)
            begin
                press_time_reg <= in_now_reg;
                hold_fired_reg <= 1'b0;
            end
            else if (hold_hit)
                hold_fired_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_ev_reg     <= ev_next;
            out_stable_reg <= deb_level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= in_valid_reg;
    end

endmodule

>>> hw/rtl/tbeq_checker.sv
// Port-level checker for the touch button event qualifier, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbeq_checker
    import tbeq_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [OutW-1:0] m_tdata
);

    logic [EvW-1:0] ev_code;
    logic           touched;
    logic           down_event;

    assign ev_code    = m_tdata[EvW-1:0];
    assign touched    = m_tdata[EvW];
    assign down_event = (ev_code == EV_PRESS) || (ev_code == EV_HOLD);

    `ASSERT_NEXT(a_out_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // press and hold only happen with the button down, release with it up
    `ASSERT_IMPLY(a_press_touched, clk, rst_n, m_tvalid && down_event, touched)
    `ASSERT_IMPLY(a_release_untouched, clk, rst_n, m_tvalid && ev_code == EV_RELEASE, !touched)

endmodule

bind touch_button_event_qualifier_unit tbeq_checker u_tbeq_checker (.*);

>>> test/tb.sv
// Self-checking testbench for the touch button event qualifier unit.
`timescale 1ns / 1ps

module tb;
    import tbeq_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          DRAIN_CYCLES = 4;      // idle margin after the last result
    localparam logic [1:0]  REG_UNUSED   = 2'd3;   // no register behind this index

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    // One directed step: either a register write or an input transfer.
    // For a transfer, 'typed' means the expected result is given in the row.
    typedef struct packed {
        row_kind_t          kind;
        logic [CfgIdxW-1:0] idx;
        logic [SampleW-1:0] val;    // register value or raw sample
        logic [TimeW-1:0]   now;
        logic               typed;
        logic [EvW-1:0]     ev;
        logic               st;
    } step_row_t;

    typedef struct packed {
        logic [EvW-1:0] ev;
        logic           stable;
    } touch_result_t;

    localparam int NUM_ROWS = 26;
    localparam step_row_t DIRECTED [NUM_ROWS] = '{
        // reset config: threshold 0, nothing is ever touched
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd0,        1'b1, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'hFFFF, 32'hFFFFFFFF, 1'b1, EV_NONE,    1'b0},
        '{ROW_CFG,  REG_THRESHOLD, 16'hFFFF, 32'd0,        1'b0, EV_NONE,    1'b0},
        '{ROW_CFG,  REG_DEBOUNCE,  16'd10,   32'd0,        1'b0, EV_NONE,    1'b0},
        // raw change restarts the timer, press only once steady for more than 10
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd100,      1'b1, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'hFFFE, 32'd105,      1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd110,      1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd111,      1'b1, EV_PRESS,   1'b1},
        // hold at exactly hold_ms is too early, one ms later it fires
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd611,      1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd612,      1'b1, EV_HOLD,    1'b1},
        '{ROW_ITEM, REG_THRESHOLD, 16'hFFFF, 32'd710,      1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'hFFFF, 32'd721,      1'b1, EV_RELEASE, 1'b0},
        // zero debounce and zero hold: press, then hold on the very next ms
        '{ROW_CFG,  REG_DEBOUNCE,  16'd0,    32'd0,        1'b0, EV_NONE,    1'b0},
        '{ROW_CFG,  REG_HOLD,      16'd0,    32'd0,        1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd800,      1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd801,      1'b1, EV_PRESS,   1'b1},
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd802,      1'b1, EV_HOLD,    1'b1},
        // time going backwards
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd5,        1'b0, EV_NONE,    1'b0},
        // unused index is ignored, then both timers at their maximum
        '{ROW_CFG,  REG_UNUSED,    16'hFFFF, 32'd0,        1'b0, EV_NONE,    1'b0},
        '{ROW_CFG,  REG_DEBOUNCE,  16'hFFFF, 32'd0,        1'b0, EV_NONE,    1'b0},
        '{ROW_CFG,  REG_HOLD,      16'hFFFF, 32'd0,        1'b0, EV_NONE,    1'b0},
        // release across the 2^32 wrap: 65535 is not enough, 65536 is
        '{ROW_ITEM, REG_THRESHOLD, 16'hFFFF, 32'hFFFFFFFF, 1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'hFFFF, 32'd65534,    1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'hFFFF, 32'd65535,    1'b1, EV_RELEASE, 1'b0},
        '{ROW_CFG,  REG_THRESHOLD, 16'h0000, 32'd0,        1'b0, EV_NONE,    1'b0},
        '{ROW_ITEM, REG_THRESHOLD, 16'h0000, 32'd70000,    1'b1, EV_NONE,    1'b0}
    };

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [InW-1:0]     s_tdata;    // [15:0] raw_sample, [47:16] now_ms
    logic               m_tvalid;
    logic               m_tready;
    logic [OutW-1:0]    m_tdata;    // [1:0] event_code, [2] stable_touched, [7:3] zero
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0]    cfg_data;

    // Register copies and button state held by the predictor.
    logic [CfgW-1:0]    thr_q;
    logic [CfgW-1:0]    deb_q;
    logic [CfgW-1:0]    hold_q;
    logic               last_raw;
    logic [TimeW-1:0]   change_t;
    logic               stable_q;
    logic [TimeW-1:0]   press_t;
    logic               hold_done;

    touch_result_t      pending_results [$];

    int                 gap_pct;
    int                 stall_pct;
    int                 cycle_count;
    int                 error_count;
    int                 sent_count;
    int                 press_count;
    int                 release_count;
    int                 hold_count;

    // Random stimulus generator state.
    logic [TimeW-1:0]   gen_now;
    logic               gen_touched;
    int                 run_left;

    touch_button_event_qualifier_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor: one debounce/hold step for an accepted sample.
    function automatic touch_result_t qualify_sample(input logic [SampleW-1:0] sample,
                                                     input logic [TimeW-1:0] now);
        logic             raw;
        logic [TimeW-1:0] since_change;
        logic [TimeW-1:0] since_press;
        touch_result_t    res;
        raw    = (sample < thr_q);
        res.ev = EV_NONE;
        // any raw change restarts the steady timer
        if (raw != last_raw)
        begin
            change_t = now;
            last_raw = raw;
        end
        since_change = now - change_t;
        if (since_change > TimeW'(deb_q) && raw != stable_q)
        begin
            stable_q = raw;
            if (raw)
            begin
                press_t   = now;
                hold_done = 1'b0;
                res.ev    = EV_PRESS;
            end
            else
                res.ev = EV_RELEASE;
        end
        // hold wins over press/release; the flag is only cleared by a press
        since_press = now - press_t;
        if (stable_q && !hold_done && since_press > TimeW'(hold_q))
        begin
            res.ev    = EV_HOLD;
            hold_done = 1'b1;
        end
        res.stable = stable_q;
        return res;
    endfunction

    // Register write at a falling edge; cfg_we is lowered by the next transfer.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_THRESHOLD: thr_q  = val;
            REG_DEBOUNCE:  deb_q  = val;
            REG_HOLD:      hold_q = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Stop sending and wait until every result is back and the pipe is empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One input transfer, with random idle cycles before it.
    task automatic send_sample(input logic [SampleW-1:0] sample, input logic [TimeW-1:0] now,
                               input logic typed, input touch_result_t given);
        touch_result_t predicted;
        cfg_we <= 1'b0;
        while ($urandom_range(99, 0) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, sample};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // accepted at this edge
        predicted = qualify_sample(sample, now);
        pending_results.push_back(typed ? given : predicted);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [CfgW-1:0] thr, input logic [CfgW-1:0] deb,
                            input logic [CfgW-1:0] hld);
        wait_idle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_HOLD, hld);
    endtask

    // Random samples: mostly steady runs of touched/untouched readings with
    // small time steps, plus single-sample glitches, full-range noise and
    // time jumps (including backwards).
    task automatic run_random(input int count, input bit pause_midway);
        int               roll;
        int               tstep;
        logic [SampleW-1:0] sample;
        touch_result_t    none_given;
        none_given = '0;
        for (int i = 0; i < count; i++)
        begin
            // pressure point: sender holds off until the output side drains
            if (pause_midway && i == count / 2)
                wait_idle();
            if (run_left == 0)
            begin
                gen_touched = ~gen_touched;
                run_left    = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13)
                                                          : $urandom_range(12, 1);
            end
            run_left--;
            roll  = $urandom_range(99, 0);
            tstep = int'(deb_q) / 4 + int'(hold_q) / 32 + 3;
            if (roll < 5)
                sample = SampleW'($urandom);
            else if ((gen_touched ^ (roll < 12)) && thr_q != '0)
                sample = SampleW'($urandom_range(int'(thr_q) - 1, 0));
            else
                sample = SampleW'($urandom_range(65535, int'(thr_q)));
            if (roll >= 95)
                gen_now = TimeW'($urandom);
            else
                gen_now = gen_now + TimeW'($urandom_range(tstep, 0));
            send_sample(sample, gen_now, 1'b0, none_given);
        end
    endtask

    // Output side: random back-pressure, changed at the falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(99, 0) >= stall_pct);

    // Result checker: every output transfer against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        touch_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual event %0d stable %0d",
                         $time, m_tdata[1:0], m_tdata[2]);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[EvW-1:0] !== want.ev)
                begin
                    $display("%0t: event_code mismatch, expected %0d actual %0d",
                             $time, want.ev, m_tdata[EvW-1:0]);
                    error_count++;
                end
                if (m_tdata[EvW] !== want.stable)
                begin
                    $display("%0t: stable_touched mismatch, expected %0d actual %0d",
                             $time, want.stable, m_tdata[EvW]);
                    error_count++;
                end
                case (want.ev)
                    EV_PRESS:   press_count++;
                    EV_RELEASE: release_count++;
                    EV_HOLD:    hold_count++;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        bit            cfg_burst;
        touch_result_t given;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        cycle_count   = 0;
        error_count   = 0;
        sent_count    = 0;
        press_count   = 0;
        release_count = 0;
        hold_count    = 0;
        gen_now       = '0;
        gen_touched   = 1'b0;
        run_left      = 0;
        cfg_burst     = 1'b0;

        // predictor at its reset state
        thr_q     = THRESHOLD_RST;
        deb_q     = DEBOUNCE_RST;
        hold_q    = HOLD_RST;
        last_raw  = 1'b0;
        change_t  = '0;
        stable_q  = 1'b0;
        press_t   = '0;
        hold_done = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table, no idling
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                if (!cfg_burst)
                    wait_idle();
                cfg_burst = 1'b1;
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
            end
            else
            begin
                cfg_burst     = 1'b0;
                given.ev      = DIRECTED[i].ev;
                given.stable  = DIRECTED[i].st;
                send_sample(DIRECTED[i].val, DIRECTED[i].now, DIRECTED[i].typed, given);
            end
        end

        // phase 1: back to back, mid threshold, short timers
        set_regs(16'h8000, 16'd20, 16'd150);
        run_random(100, 1'b0);

        // phase 2: sender idles about half the time, random settings
        gap_pct = 49;
        set_regs(CfgW'($urandom_range(65535, 1)), CfgW'($urandom_range(60, 0)),
                 CfgW'($urandom_range(400, 0)));
        run_random(100, 1'b1);

        // phase 3: receiver stalls about half the time, all registers at max
        gap_pct   = 0;
        stall_pct = 49;
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(100, 1'b0);

        // phase 4: both sides idle a quarter of the time, zero timers
        gap_pct   = 24;
        stall_pct = 24;
        set_regs(CfgW'($urandom_range(65535, 1)), 16'd0, 16'd0);
        run_random(100, 1'b0);

        wait_idle();
        repeat (10) @(negedge clk);

        $display("Sent %0d samples over four idle/stall mixes and several register settings;",
                 sent_count);
        $display("checked %0d press, %0d release and %0d hold events.",
                 press_count, release_count, hold_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tbeq_pkg.sv
hw/rtl/touch_button_event_qualifier_unit.sv
hw/rtl/tbeq_checker.sv
test/tb.sv
